[rtl/mars_pkg.sv]
// ---------------------------------------------------------------------------
// mars_pkg
// shared types and constants of the moving average reversion signal
// ---------------------------------------------------------------------------
package mars_pkg;

   // field widths fixed by the interface
   localparam int CSR_INDEX_BITS     = 2;
   localparam int CSR_DATA_BITS      = 32;
   localparam int WINDOW_LENGTH_BITS = 7;
   localparam int BAND_BITS          = 32;
   localparam int QTY_BITS           = 16;
   localparam int SYMBOL_BITS        = 16;
   localparam int TIME_BITS          = 64;
   localparam int PRICE_PORT_BITS    = 32;
   localparam int ACTION_BITS        = 2;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] REG_WINDOW_LENGTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_ENTRY_BAND     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TRADE_QUANTITY = 2'd2;

   // register reset values
   localparam int                     WINDOW_LENGTH_RESET = 5;
   localparam logic [BAND_BITS-1:0]   ENTRY_BAND_RESET    = 32'd200;
   localparam logic [QTY_BITS-1:0]    TRADE_QUANTITY_RESET = 16'd1;

   // command codes
   localparam logic CMD_TICK  = 1'b0;
   localparam logic CMD_CLOSE = 1'b1;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_NONE  = 2'd0,
      ACT_ENTER = 2'd1,
      ACT_EXIT  = 2'd2,
      ACT_CLOSE = 2'd3
   } action_type;

   // control of one pipeline stage
   typedef struct packed {
      logic valid;
      logic close;   // close-out command rather than a price tick
      logic full;    // window holds window_length prices after this tick
   } stage_ctl_type;

endpackage

[rtl/mars_ram.sv]
// ---------------------------------------------------------------------------
// mars_ram
// generic single-clock ram, one write and one registered read port
// ---------------------------------------------------------------------------
module mars_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first: a read and write of the same entry returns the old data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/mars_window.sv]
// ---------------------------------------------------------------------------
// mars_window
// price ring, running window sum and cross-multiplied products
// ---------------------------------------------------------------------------
module mars_window #(
   parameter int MAX_WINDOW = 64,
   parameter int PRICE_BITS = 32,
   localparam int LEN_W  = $clog2(MAX_WINDOW + 1),
   localparam int SUM_W  = PRICE_BITS + LEN_W,
   localparam int BN_W   = mars_pkg::BAND_BITS + LEN_W,
   localparam int CMP_W  = ((PRICE_BITS > mars_pkg::BAND_BITS) ?
                            PRICE_BITS : mars_pkg::BAND_BITS) + LEN_W + 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                clear,
   input  logic [LEN_W-1:0]                    win_len,
   input  logic [mars_pkg::BAND_BITS-1:0]      entry_band,
   // upstream
   input  logic                                in_valid,
   output logic                                in_stall,
   input  logic                                in_cmd,
   input  logic [PRICE_BITS-1:0]               in_price,
   input  logic [mars_pkg::SYMBOL_BITS-1:0]    in_symbol,
   input  logic [mars_pkg::TIME_BITS-1:0]      in_time,
   // downstream
   output mars_pkg::stage_ctl_type             dn_ctl,
   input  logic                                dn_ready,
   output logic [PRICE_BITS-1:0]               dn_price,
   output logic [mars_pkg::TIME_BITS-1:0]      dn_time,
   output logic [mars_pkg::SYMBOL_BITS-1:0]    dn_symbol,
   output logic [SUM_W-1:0]                    dn_pn,
   output logic [CMP_W-1:0]                    dn_pnb,
   output logic [SUM_W-1:0]                    dn_sum
);

   localparam int PTR_W = $clog2(MAX_WINDOW);

   // history state
   logic [PTR_W-1:0]                 ptr_ff, ptr_in;
   logic [LEN_W-1:0]                 fill_ff, fill_in;
   logic [SUM_W-1:0]                 sum_ff, sum_in;
   logic [PRICE_BITS-1:0]            last_price_ff;
   logic [mars_pkg::TIME_BITS-1:0]   last_time_ff;

   // stage 1
   mars_pkg::stage_ctl_type          s1_ctl_ff, s1_ctl_in;
   logic                             s1_sub_ff;
   logic [PRICE_BITS-1:0]            s1_price_ff;
   logic [mars_pkg::TIME_BITS-1:0]   s1_time_ff;
   logic [mars_pkg::SYMBOL_BITS-1:0] s1_sym_ff;
   logic [SUM_W-1:0]                 s1_pn_ff;
   logic [BN_W-1:0]                  s1_bn_ff;

   // stage 2
   mars_pkg::stage_ctl_type          s2_ctl_ff, s2_ctl_in;
   logic [PRICE_BITS-1:0]            s2_price_ff;
   logic [mars_pkg::TIME_BITS-1:0]   s2_time_ff;
   logic [mars_pkg::SYMBOL_BITS-1:0] s2_sym_ff;
   logic [SUM_W-1:0]                 s2_pn_ff;
   logic [CMP_W-1:0]                 s2_pnb_ff;

   logic                  s1_ready, s2_ready, accept, tick_acc, s1_move;
   logic                  full_before, full_after;
   logic [LEN_W-1:0]      ptr_inc;
   logic [LEN_W:0]        fill_inc;
   logic [PRICE_BITS-1:0] old_price;
   logic [SUM_W-1:0]      pn_c;
   logic [BN_W-1:0]       bn_c;

   assign s2_ready = !s2_ctl_ff.valid || dn_ready;
   assign s1_ready = !s1_ctl_ff.valid || s2_ready;
   assign in_stall = !s1_ready;
   assign accept   = in_valid && s1_ready;
   assign tick_acc = accept && (in_cmd == mars_pkg::CMD_TICK);
   assign s1_move  = s1_ctl_ff.valid && s2_ready;

   assign full_before = (fill_ff >= win_len);
   assign fill_inc    = {1'b0, fill_ff} + {{LEN_W{1'b0}}, 1'b1};
   assign full_after  = (fill_inc >= {1'b0, win_len});
   assign ptr_inc     = LEN_W'(ptr_ff) + LEN_W'(1);

   always_comb begin
      ptr_in  = ptr_ff;
      fill_in = fill_ff;
      if (clear) begin
         ptr_in  = '0;
         fill_in = '0;
      end else if (tick_acc) begin
         ptr_in = (ptr_inc >= win_len) ? '0 : PTR_W'(ptr_inc);
         if (!full_before) begin
            fill_in = LEN_W'(fill_inc);
         end
      end
   end

   // cross products formed on the way in
   assign pn_c = {{LEN_W{1'b0}}, in_price} * {{PRICE_BITS{1'b0}}, win_len};
   assign bn_c = {{LEN_W{1'b0}}, entry_band} * {{mars_pkg::BAND_BITS{1'b0}}, win_len};

   mars_ram #(
      .WIDTH (PRICE_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (tick_acc),
      .wr_addr (ptr_ff),
      .wr_data (in_price),
      .rd_en   (tick_acc),
      .rd_addr (ptr_ff),
      .rd_data (old_price)
   );

   // running sum: drop the evicted price once the window is full
   always_comb begin
      sum_in = sum_ff;
      if (clear) begin
         sum_in = '0;
      end else if (s1_move && !s1_ctl_ff.close) begin
         sum_in = sum_ff - (s1_sub_ff ? SUM_W'(old_price) : '0) + SUM_W'(s1_price_ff);
      end
   end

   always_comb begin
      s1_ctl_in = s1_ctl_ff;
      if (s1_ready) begin
         s1_ctl_in.valid = accept;
         s1_ctl_in.close = in_cmd;
         s1_ctl_in.full  = full_after;
      end
      s2_ctl_in = s2_ctl_ff;
      if (s2_ready) begin
         s2_ctl_in       = s1_ctl_ff;
         s2_ctl_in.valid = s1_ctl_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff        <= '0;
         fill_ff       <= '0;
         sum_ff        <= '0;
         last_price_ff <= '0;
         last_time_ff  <= '0;
         s1_ctl_ff     <= '0;
         s2_ctl_ff     <= '0;
      end else begin
         ptr_ff    <= ptr_in;
         fill_ff   <= fill_in;
         sum_ff    <= sum_in;
         s1_ctl_ff <= s1_ctl_in;
         s2_ctl_ff <= s2_ctl_in;
         if (tick_acc) begin
            last_price_ff <= in_price;
            last_time_ff  <= in_time;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sub_ff   <= full_before;
         s1_price_ff <= (in_cmd == mars_pkg::CMD_CLOSE) ? last_price_ff : in_price;
         s1_time_ff  <= (in_cmd == mars_pkg::CMD_CLOSE) ? last_time_ff : in_time;
         s1_sym_ff   <= in_symbol;
         s1_pn_ff    <= pn_c;
         s1_bn_ff    <= bn_c;
      end
      if (s1_move) begin
         s2_price_ff <= s1_price_ff;
         s2_time_ff  <= s1_time_ff;
         s2_sym_ff   <= s1_sym_ff;
         s2_pn_ff    <= s1_pn_ff;
         s2_pnb_ff   <= CMP_W'(s1_pn_ff) + CMP_W'(s1_bn_ff);
      end
   end

   assign dn_ctl    = s2_ctl_ff;
   assign dn_price  = s2_price_ff;
   assign dn_time   = s2_time_ff;
   assign dn_symbol = s2_sym_ff;
   assign dn_pn     = s2_pn_ff;
   assign dn_pnb    = s2_pnb_ff;
   assign dn_sum    = sum_ff;

endmodule

[rtl/mars_decide.sv]
// ---------------------------------------------------------------------------
// mars_decide
// entry, exit and close-out decision, position state and result register
// ---------------------------------------------------------------------------
module mars_decide #(
   parameter int MAX_WINDOW = 64,
   parameter int PRICE_BITS = 32,
   localparam int LEN_W  = $clog2(MAX_WINDOW + 1),
   localparam int SUM_W  = PRICE_BITS + LEN_W,
   localparam int CMP_W  = ((PRICE_BITS > mars_pkg::BAND_BITS) ?
                            PRICE_BITS : mars_pkg::BAND_BITS) + LEN_W + 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [mars_pkg::QTY_BITS-1:0]        trade_quantity,
   // upstream
   input  mars_pkg::stage_ctl_type              up_ctl,
   output logic                                 up_ready,
   input  logic [PRICE_BITS-1:0]                up_price,
   input  logic [mars_pkg::TIME_BITS-1:0]       up_time,
   input  logic [mars_pkg::SYMBOL_BITS-1:0]     up_symbol,
   input  logic [SUM_W-1:0]                     up_pn,
   input  logic [CMP_W-1:0]                     up_pnb,
   input  logic [SUM_W-1:0]                     up_sum,
   // result
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mars_pkg::ACTION_BITS-1:0]     rsp_action,
   output logic [mars_pkg::PRICE_PORT_BITS-1:0] rsp_trade_price,
   output logic [mars_pkg::TIME_BITS-1:0]       rsp_trade_time,
   output logic [mars_pkg::SYMBOL_BITS-1:0]     rsp_trade_symbol,
   output logic [mars_pkg::QTY_BITS-1:0]        rsp_trade_size
);

   logic                                 pos_open_ff, pos_open_in;
   logic [mars_pkg::SYMBOL_BITS-1:0]     open_sym_ff, open_sym_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   mars_pkg::action_type                 act_ff, act_c;
   logic [mars_pkg::PRICE_PORT_BITS-1:0] price_ff, price_c;
   logic [mars_pkg::TIME_BITS-1:0]       time_ff, time_c;
   logic [mars_pkg::SYMBOL_BITS-1:0]     sym_ff, sym_c;
   logic [mars_pkg::QTY_BITS-1:0]        size_ff, size_c;
   logic                                 take;

   assign up_ready = !rsp_valid_ff || !rsp_stall;
   assign take     = up_ctl.valid && up_ready;

   always_comb begin
      act_c = mars_pkg::ACT_NONE;
      if (up_ctl.close) begin
         if (pos_open_ff && (up_price != '0)) begin
            act_c = mars_pkg::ACT_CLOSE;
         end
      end else if (up_ctl.full) begin
         if (!pos_open_ff) begin
            if (up_pnb < CMP_W'(up_sum)) begin
               act_c = mars_pkg::ACT_ENTER;
            end
         end else if (up_pn >= up_sum) begin
            act_c = mars_pkg::ACT_EXIT;
         end
      end
   end

   always_comb begin
      price_c     = '0;
      time_c      = '0;
      sym_c       = '0;
      size_c      = '0;
      pos_open_in = pos_open_ff;
      open_sym_in = open_sym_ff;
      case (act_c)
         mars_pkg::ACT_ENTER: begin
            price_c     = mars_pkg::PRICE_PORT_BITS'(up_price);
            time_c      = up_time;
            sym_c       = up_symbol;
            size_c      = trade_quantity;
            pos_open_in = 1'b1;
            open_sym_in = up_symbol;
         end
         mars_pkg::ACT_EXIT, mars_pkg::ACT_CLOSE: begin
            price_c     = mars_pkg::PRICE_PORT_BITS'(up_price);
            time_c      = up_time;
            sym_c       = open_sym_ff;
            size_c      = trade_quantity;
            pos_open_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_open_ff  <= 1'b0;
         open_sym_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            pos_open_ff <= pos_open_in;
            open_sym_ff <= open_sym_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         act_ff   <= act_c;
         price_ff <= price_c;
         time_ff  <= time_c;
         sym_ff   <= sym_c;
         size_ff  <= size_c;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action       = act_ff;
   assign rsp_trade_price  = price_ff;
   assign rsp_trade_time   = time_ff;
   assign rsp_trade_symbol = sym_ff;
   assign rsp_trade_size   = size_ff;

endmodule

[rtl/moving_average_reversion_signal.sv]
// ---------------------------------------------------------------------------
// moving_average_reversion_signal
// mean-reversion entry and exit signal over a moving window of prices
// ---------------------------------------------------------------------------
// The block takes one transaction per clock cycle while req_stall is low,
// price ticks and close-out commands alike, and returns exactly one result
// transaction for each, in order, from its result register.
// The rate is set by the price ring: one memory of MAX_WINDOW entries that is
// read and written at the same entry in the cycle a tick is accepted (the
// read returns the price leaving the window), followed by one stage that
// updates the running sum and one stage that compares price*N and
// (price + band)*N against that sum. No division is used anywhere. The ring
// needs no clearing pass: a fill count guards every read, so the block
// accepts transactions straight out of reset. Writing window_length clears
// the history (fill count, write pointer and sum) but leaves an open
// position open; configuration writes are expected only while the block is
// idle. Results with action none carry zeros in all other fields.
// ---------------------------------------------------------------------------
module moving_average_reversion_signal #(
   parameter int MAX_WINDOW = 64,
   parameter int PRICE_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // tick transactions
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_command,
   input  logic [mars_pkg::PRICE_PORT_BITS-1:0] req_price,
   input  logic [mars_pkg::SYMBOL_BITS-1:0]     req_symbol_id,
   input  logic [mars_pkg::TIME_BITS-1:0]       req_tick_time,
   // result transactions
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mars_pkg::ACTION_BITS-1:0]     rsp_action,
   output logic [mars_pkg::PRICE_PORT_BITS-1:0] rsp_trade_price,
   output logic [mars_pkg::TIME_BITS-1:0]       rsp_trade_time,
   output logic [mars_pkg::SYMBOL_BITS-1:0]     rsp_trade_symbol,
   output logic [mars_pkg::QTY_BITS-1:0]        rsp_trade_size,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mars_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [mars_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   localparam int LEN_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W = PRICE_BITS + LEN_W;
   localparam int CMP_W = ((PRICE_BITS > mars_pkg::BAND_BITS) ?
                           PRICE_BITS : mars_pkg::BAND_BITS) + LEN_W + 1;
   // reset window length, held to the supported maximum
   localparam logic [LEN_W-1:0] LEN_RESET =
      LEN_W'((mars_pkg::WINDOW_LENGTH_RESET > MAX_WINDOW) ?
             MAX_WINDOW : mars_pkg::WINDOW_LENGTH_RESET);

   // configuration registers
   logic [LEN_W-1:0]               win_len_ff, win_len_in;
   logic [mars_pkg::BAND_BITS-1:0] band_ff;
   logic [mars_pkg::QTY_BITS-1:0]  qty_ff;

   logic                                      csr_write, clear_hist;
   logic [mars_pkg::WINDOW_LENGTH_BITS-1:0]   len_raw;

   // window to decision stage
   mars_pkg::stage_ctl_type          dn_ctl;
   logic                             dn_ready;
   logic [PRICE_BITS-1:0]            dn_price;
   logic [mars_pkg::TIME_BITS-1:0]   dn_time;
   logic [mars_pkg::SYMBOL_BITS-1:0] dn_symbol;
   logic [SUM_W-1:0]                 dn_pn;
   logic [CMP_W-1:0]                 dn_pnb;
   logic [SUM_W-1:0]                 dn_sum;

   // register port never back-pressures
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign clear_hist = csr_write && (csr_index == mars_pkg::REG_WINDOW_LENGTH);
   assign len_raw    = csr_data[mars_pkg::WINDOW_LENGTH_BITS-1:0];

   // zero length reads as one, anything past the ring depth as the depth
   always_comb begin
      if (len_raw == '0) begin
         win_len_in = LEN_W'(1);
      end else if (32'(len_raw) > 32'(MAX_WINDOW)) begin
         win_len_in = LEN_W'(MAX_WINDOW);
      end else begin
         win_len_in = LEN_W'(len_raw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_len_ff <= LEN_RESET;
         band_ff    <= mars_pkg::ENTRY_BAND_RESET;
         qty_ff     <= mars_pkg::TRADE_QUANTITY_RESET;
      end else if (csr_write) begin
         case (csr_index)
            mars_pkg::REG_WINDOW_LENGTH:  win_len_ff <= win_len_in;
            mars_pkg::REG_ENTRY_BAND:     band_ff    <= csr_data;
            mars_pkg::REG_TRADE_QUANTITY: qty_ff     <= csr_data[mars_pkg::QTY_BITS-1:0];
            default: begin
               // unknown index, write dropped
            end
         endcase
      end
   end

   // price ring, running sum and products
   mars_window #(
      .MAX_WINDOW (MAX_WINDOW),
      .PRICE_BITS (PRICE_BITS)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .clear      (clear_hist),
      .win_len    (win_len_ff),
      .entry_band (band_ff),
      .in_valid   (req_valid),
      .in_stall   (req_stall),
      .in_cmd     (req_command),
      .in_price   (PRICE_BITS'(req_price)),
      .in_symbol  (req_symbol_id),
      .in_time    (req_tick_time),
      .dn_ctl     (dn_ctl),
      .dn_ready   (dn_ready),
      .dn_price   (dn_price),
      .dn_time    (dn_time),
      .dn_symbol  (dn_symbol),
      .dn_pn      (dn_pn),
      .dn_pnb     (dn_pnb),
      .dn_sum     (dn_sum)
   );

   // position tracking and result register
   mars_decide #(
      .MAX_WINDOW (MAX_WINDOW),
      .PRICE_BITS (PRICE_BITS)
   ) u_decide (
      .clock            (clock),
      .reset            (reset),
      .trade_quantity   (qty_ff),
      .up_ctl           (dn_ctl),
      .up_ready         (dn_ready),
      .up_price         (dn_price),
      .up_time          (dn_time),
      .up_symbol        (dn_symbol),
      .up_pn            (dn_pn),
      .up_pnb           (dn_pnb),
      .up_sum           (dn_sum),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_action       (rsp_action),
      .rsp_trade_price  (rsp_trade_price),
      .rsp_trade_time   (rsp_trade_time),
      .rsp_trade_symbol (rsp_trade_symbol),
      .rsp_trade_size   (rsp_trade_size)
   );

endmodule

[tb/moving_average_reversion_signal_tb.sv]
// ---------------------------------------------------------------------------
// moving_average_reversion_signal_tb
// self-checking testbench of the moving average reversion signal
// ---------------------------------------------------------------------------
// Drives price ticks and close-out commands into the block and predicts each
// result transaction with a behavioral model of the window, the running sum
// and the open position kept inside this module. Directed tests cover
// entries, exits, close-outs, a zero last price and the register limits.
// Random phases then run under several register settings and idle patterns.
// A backpressure test stalls the result side long enough to fill the
// pipeline, and then drains everything before sending again.
// ---------------------------------------------------------------------------
module moving_average_reversion_signal_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WINDOW      = 64;
   localparam int DRAIN_CYCLES    = 8;     // pipeline is three deep, keep slack
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PHASE_COUNT     = 12;
   localparam int PHASE_ITEMS     = 110;
   localparam int EXPECT_DEPTH    = 64;    // far above what can be in flight
   localparam int EXPECT_PTR_W    = 6;

   // index with no register behind it
   localparam logic [mars_pkg::CSR_INDEX_BITS-1:0] REG_UNMAPPED = 2'd3;

   typedef struct packed {
      logic                                 command;
      logic [mars_pkg::PRICE_PORT_BITS-1:0] price;
      logic [mars_pkg::SYMBOL_BITS-1:0]     symbol;
      logic [mars_pkg::TIME_BITS-1:0]       stamp;
   } tick_type;

   typedef struct packed {
      mars_pkg::action_type                 action;
      logic [mars_pkg::PRICE_PORT_BITS-1:0] price;
      logic [mars_pkg::TIME_BITS-1:0]       stamp;
      logic [mars_pkg::SYMBOL_BITS-1:0]     symbol;
      logic [mars_pkg::QTY_BITS-1:0]        size;
   } trade_type;

   // every input starts at a known value
   logic                                 clock         = 1'b0;
   logic                                 reset         = 1'b1;
   logic                                 req_valid     = 1'b0;
   logic                                 req_stall;
   logic                                 req_command   = mars_pkg::CMD_TICK;
   logic [mars_pkg::PRICE_PORT_BITS-1:0] req_price     = '0;
   logic [mars_pkg::SYMBOL_BITS-1:0]     req_symbol_id = '0;
   logic [mars_pkg::TIME_BITS-1:0]       req_tick_time = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall     = 1'b0;
   logic [mars_pkg::ACTION_BITS-1:0]     rsp_action;
   logic [mars_pkg::PRICE_PORT_BITS-1:0] rsp_trade_price;
   logic [mars_pkg::TIME_BITS-1:0]       rsp_trade_time;
   logic [mars_pkg::SYMBOL_BITS-1:0]     rsp_trade_symbol;
   logic [mars_pkg::QTY_BITS-1:0]        rsp_trade_size;
   logic                                 csr_valid     = 1'b0;
   logic                                 csr_ready;
   logic [mars_pkg::CSR_INDEX_BITS-1:0]  csr_index     = '0;
   logic [mars_pkg::CSR_DATA_BITS-1:0]   csr_data      = '0;

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   moving_average_reversion_signal #(
      .MAX_WINDOW (MAX_WINDOW),
      .PRICE_BITS (32)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_price        (req_price),
      .req_symbol_id    (req_symbol_id),
      .req_tick_time    (req_tick_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_action       (rsp_action),
      .rsp_trade_price  (rsp_trade_price),
      .rsp_trade_time   (rsp_trade_time),
      .rsp_trade_symbol (rsp_trade_symbol),
      .rsp_trade_size   (rsp_trade_size),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   // ------------------------------------------------------------------------
   // signal model: price window, running sum, position and registers
   // ------------------------------------------------------------------------
   logic [mars_pkg::PRICE_PORT_BITS-1:0] ring_prices [MAX_WINDOW];
   int unsigned                          ring_wp      = 0;
   int unsigned                          ring_fill    = 0;
   logic [63:0]                          price_sum    = '0;
   logic                                 long_open    = 1'b0;
   logic [mars_pkg::SYMBOL_BITS-1:0]     long_symbol  = '0;
   logic [mars_pkg::PRICE_PORT_BITS-1:0] last_price   = '0;
   logic [mars_pkg::TIME_BITS-1:0]       last_stamp   = '0;
   int unsigned                          window_len   = mars_pkg::WINDOW_LENGTH_RESET;
   logic [mars_pkg::BAND_BITS-1:0]       band         = mars_pkg::ENTRY_BAND_RESET;
   logic [mars_pkg::QTY_BITS-1:0]        quantity     = mars_pkg::TRADE_QUANTITY_RESET;

   // predictions in acceptance order, a ring with write and read pointers
   trade_type               expected_trades [EXPECT_DEPTH];
   logic [EXPECT_PTR_W-1:0] expect_wr_ptr  = '0;
   logic [EXPECT_PTR_W-1:0] expect_rd_ptr  = '0;
   int                      mismatch_count = 0;

   // idle pattern of both sides, in percent per cycle
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_off_left  = 0;

   // shaping of random prices around a mean
   int unsigned mid_price  = 100000;
   int unsigned price_span = 250;

   function automatic trade_type predict_trade(tick_type t);
      trade_type   r;
      logic [63:0] price_n;
      logic [63:0] band_n;
      int unsigned wp;
      r = '0;
      r.action = mars_pkg::ACT_NONE;
      if (t.command == mars_pkg::CMD_CLOSE) begin
         // close-out uses the last tick, its own fields are ignored
         if (long_open && last_price != 0) begin
            r.action = mars_pkg::ACT_CLOSE;
            r.price  = last_price;
            r.stamp  = last_stamp;
            r.symbol = long_symbol;
            r.size   = quantity;
            long_open = 1'b0;
         end
         return r;
      end
      last_price = t.price;
      last_stamp = t.stamp;
      wp = ring_wp;
      if (wp >= window_len) wp = 0;
      // a full window drops its oldest price before taking the new one
      if (ring_fill >= window_len) price_sum -= 64'(ring_prices[wp]);
      else ring_fill++;
      ring_prices[wp] = t.price;
      price_sum += 64'(t.price);
      wp++;
      if (wp >= window_len) wp = 0;
      ring_wp = wp;
      if (ring_fill < window_len) return r;
      // mean compared by cross-multiplication with the window length
      price_n = 64'(t.price) * 64'(window_len);
      band_n  = 64'(band) * 64'(window_len);
      if (!long_open) begin
         if (price_n + band_n < price_sum) begin
            long_open   = 1'b1;
            long_symbol = t.symbol;
            r.action = mars_pkg::ACT_ENTER;
            r.price  = t.price;
            r.stamp  = t.stamp;
            r.symbol = t.symbol;
            r.size   = quantity;
         end
      end else if (price_n >= price_sum) begin
         long_open = 1'b0;
         r.action = mars_pkg::ACT_EXIT;
         r.price  = t.price;
         r.stamp  = t.stamp;
         r.symbol = long_symbol;
         r.size   = quantity;
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   // payload changes at the falling edge only; a stalled transaction holds
   task automatic send_item(tick_type t);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_command   = t.command;
      req_price     = t.price;
      req_symbol_id = t.symbol;
      req_tick_time = t.stamp;
      req_valid     = 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      expected_trades[expect_wr_ptr] = predict_trade(t);
      expect_wr_ptr = expect_wr_ptr + EXPECT_PTR_W'(1);
   endtask

   // stop offering, wait for every result, then let the pipeline settle
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (expect_rd_ptr != expect_wr_ptr) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [mars_pkg::CSR_INDEX_BITS-1:0] index,
                                 logic [mars_pkg::CSR_DATA_BITS-1:0] data);
      int unsigned w;
      drain_results();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data  = data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (index)
         mars_pkg::REG_WINDOW_LENGTH: begin
            // zero reads as one, oversize clamps, history is cleared
            w = 32'(data[mars_pkg::WINDOW_LENGTH_BITS-1:0]);
            if (w == 0) w = 1;
            if (w > MAX_WINDOW) w = MAX_WINDOW;
            window_len = w;
            ring_wp    = 0;
            ring_fill  = 0;
            price_sum  = '0;
         end
         mars_pkg::REG_ENTRY_BAND:     band     = data[mars_pkg::BAND_BITS-1:0];
         mars_pkg::REG_TRADE_QUANTITY: quantity = data[mars_pkg::QTY_BITS-1:0];
         default: ;  // unmapped index, write is dropped
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_idling(int send_pct, int recv_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // mostly prices around the mean, some wild prices and close-outs
   function automatic tick_type random_tick();
      tick_type    t;
      int unsigned pick;
      pick     = $urandom_range(99);
      t.symbol = 16'($urandom);
      t.stamp  = {$urandom, $urandom};
      t.command = (pick < 8) ? mars_pkg::CMD_CLOSE : mars_pkg::CMD_TICK;
      if (pick < 16) t.price = $urandom;
      else t.price = mid_price - 3 * price_span + $urandom_range(4 * price_span);
      return t;
   endfunction

   // ------------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------------
   // the long hold-off counts down here; otherwise a random stall per cycle
   always @(negedge clock) begin
      if (hold_off_left > 0) begin
         rsp_stall = 1'b1;
         hold_off_left--;
      end else begin
         rsp_stall = ($urandom_range(99) < recv_stall_pct);
      end
   end

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         $display("%0t mismatch on %s: expected %0h actual %0h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // every accepted result is matched against the oldest prediction
   always @(posedge clock) begin
      trade_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expect_rd_ptr == expect_wr_ptr) begin
            $display("%0t unexpected result transaction: action %0h price %0h",
                     $time, rsp_action, rsp_trade_price);
            mismatch_count++;
         end else begin
            want = expected_trades[expect_rd_ptr];
            expect_rd_ptr = expect_rd_ptr + EXPECT_PTR_W'(1);
            check_field("action", 64'(want.action), 64'(rsp_action));
            check_field("trade_price", 64'(want.price), 64'(rsp_trade_price));
            check_field("trade_time", want.stamp, rsp_trade_time);
            check_field("trade_symbol", 64'(want.symbol), 64'(rsp_trade_symbol));
            check_field("trade_size", 64'(want.size), 64'(rsp_trade_size));
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // reset registers: window 5, band 200, quantity 1
   task automatic test_basic_trading();
      // close-out with nothing open and no tick seen yet
      send_item('{mars_pkg::CMD_CLOSE, 32'd123, 16'd7, 64'd99});
      // fill the window, the fifth tick is the first decision
      for (int i = 0; i < 5; i++) begin
         send_item('{mars_pkg::CMD_TICK, 32'd10000, 16'h1234, 64'(1000 + i)});
      end
      // far below the mean, extreme symbol and time
      send_item('{mars_pkg::CMD_TICK, 32'd9000, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF});
      // reversion exit reports the open symbol, not the tick symbol
      send_item('{mars_pkg::CMD_TICK, 32'd20000, 16'h0000, 64'h0});
      send_item('{mars_pkg::CMD_TICK, 32'd5000, 16'h00A5, 64'd5000});
      // close-out fields are ignored, exit is at the last tick
      send_item('{mars_pkg::CMD_CLOSE, 32'hFFFF_FFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF});
      send_item('{mars_pkg::CMD_CLOSE, 32'd1, 16'd2, 64'd3});
   endtask

   task automatic test_zero_last_price();
      // enter at price zero, then close-out has no price to use
      send_item('{mars_pkg::CMD_TICK, 32'd0, 16'h5A5A, 64'd7000});
      send_item('{mars_pkg::CMD_CLOSE, 32'd0, 16'd0, 64'd0});
      // position is still open, the largest price exits it
      send_item('{mars_pkg::CMD_TICK, 32'hFFFF_FFFF, 16'hA5A5, 64'h8000_0000_0000_0000});
   endtask

   task automatic test_register_limits();
      write_register(mars_pkg::REG_TRADE_QUANTITY, 32'hFFFF_FFFF);
      write_register(mars_pkg::REG_ENTRY_BAND, 32'd0);
      // window zero acts as one
      write_register(mars_pkg::REG_WINDOW_LENGTH, 32'hFFFF_FF80);
      send_item('{mars_pkg::CMD_TICK, 32'd500, 16'd1, 64'd1});
      // oversize window clamps to the maximum, never fills here
      write_register(mars_pkg::REG_WINDOW_LENGTH, 32'd100);
      for (int i = 0; i < 3; i++) begin
         send_item('{mars_pkg::CMD_TICK, 32'(400 + i), 16'd2, 64'(i)});
      end
      write_register(mars_pkg::REG_ENTRY_BAND, 32'hFFFF_FFFF);
      // unmapped index must leave every register alone
      write_register(REG_UNMAPPED, 32'h0000_0001);
      write_register(mars_pkg::REG_ENTRY_BAND, 32'd0);
      write_register(mars_pkg::REG_WINDOW_LENGTH, 32'd2);
      send_item('{mars_pkg::CMD_TICK, 32'd1000, 16'h0101, 64'd10});
      send_item('{mars_pkg::CMD_TICK, 32'd1000, 16'h0202, 64'd11});
      send_item('{mars_pkg::CMD_TICK, 32'd0, 16'h0303, 64'd12});
      // quantity change and window rewrite while the position is open
      write_register(mars_pkg::REG_TRADE_QUANTITY, 32'd7);
      write_register(mars_pkg::REG_WINDOW_LENGTH, 32'd3);
      for (int i = 0; i < 3; i++) begin
         send_item('{mars_pkg::CMD_TICK, 32'd100, 16'h0404, 64'(20 + i)});
      end
   endtask

   task automatic test_random_phases();
      logic [mars_pkg::WINDOW_LENGTH_BITS-1:0] w;
      logic [mars_pkg::BAND_BITS-1:0]          b;
      logic [mars_pkg::QTY_BITS-1:0]           q;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       w = 7'd1;
            1:       w = 7'd64;
            2:       w = 7'd0;
            3:       w = 7'd127;
            default: w = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                                  : 7'($urandom_range(1, 12));
         endcase
         b = (phase == 3) ? 32'hFFFF_FFFF : (phase == 4) ? 32'd0 : $urandom_range(400);
         q = (phase == 0) ? 16'hFFFF : (phase == 1) ? 16'h0 : 16'($urandom_range(1, 65535));
         write_register(mars_pkg::REG_WINDOW_LENGTH, ($urandom & ~32'h7F) | 32'(w));
         write_register(mars_pkg::REG_ENTRY_BAND, b);
         write_register(mars_pkg::REG_TRADE_QUANTITY, {16'($urandom), q});
         price_span = (b > 400) ? 1000 : b + 50;
         mid_price  = $urandom_range(5000, 2_000_000);
         case (phase % 4)
            0: set_idling(0, 0);
            1: set_idling(65, 0);
            2: set_idling(0, 65);
            default: set_idling(29, 29);
         endcase
         repeat (PHASE_ITEMS) send_item(random_tick());
      end
   endtask

   task automatic test_backpressure();
      write_register(mars_pkg::REG_WINDOW_LENGTH, 32'd4);
      write_register(mars_pkg::REG_ENTRY_BAND, 32'd50);
      write_register(mars_pkg::REG_TRADE_QUANTITY, 32'd3);
      price_span = 100;
      mid_price  = 50000;
      set_idling(0, 0);
      // result side holds off while ticks keep coming, input must stall
      hold_off_left = HOLD_OFF_CYCLES;
      repeat (60) send_item(random_tick());
      // sender pauses until every result is back
      drain_results();
      set_idling(29, 29);
      repeat (20) send_item(random_tick());
   endtask

   // ------------------------------------------------------------------------
   // sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_basic_trading();
      test_zero_last_price();
      test_register_limits();
      test_random_phases();
      test_backpressure();
      drain_results();
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
